>>> hdl/number_text_to_bit_string_unit_assert.svh
// Assertion macros shared by the RTL of the number text converter.
`ifndef NUMBER_TEXT_TO_BIT_STRING_UNIT_ASSERT_SVH
`define NUMBER_TEXT_TO_BIT_STRING_UNIT_ASSERT_SVH

`ifndef SYNTH
`define NTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("nts assertion failed");
`define NTS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("nts reset assertion failed");
`else
`define NTS_ASSERT(lbl, prop)
`define NTS_ASSERT_RST(lbl, prop)
`endif

`endif

>>> hdl/nts_pkg.sv
package nts_pkg;

  localparam int unsigned AccW = 64;
  localparam int unsigned CntW = 7;

  localparam logic [1:0] CFG_HEX_DEFAULT  = 2'd0;
  localparam logic [1:0] CFG_WIDTH_SELECT = 2'd1;

  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;
  localparam logic [1:0] WSEL_64 = 2'd3;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [4:0] BIT_CHAR_HI = 5'b11000;

  typedef struct packed {
    logic            push;
    logic [AccW-1:0] value;
  } q_push_t;

  typedef struct packed {
    logic            valid;
    logic [AccW-1:0] value;
  } q_head_t;

endpackage

>>> hdl/nts_front.sv
module nts_front
  import nts_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       hex_default_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       end_of_stream_i,
  input  logic       q_full_i,
  output q_push_t    q_push_o
);

  logic [AccW-1:0] acc_q, acc_d;
  logic            seen_q, seen_d;
  logic            hov_q, hov_d;

  logic [7:0]      c_lc;
  logic            is_x, is_dec, is_alpha, is_delim, hex, take, accept, emit;
  logic [3:0]      dval;
  logic [AccW-1:0] acc_hex, acc_dec, acc_new;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign c_lc     = (char_in_i >= CH_UA && char_in_i <= CH_UZ) ? (char_in_i + CASE_OFS)
                                                               : char_in_i;
  assign is_x     = (c_lc == CH_X);
  assign is_dec   = (c_lc >= CH_0) && (c_lc <= CH_9);
  assign is_alpha = (c_lc >= CH_A) && (c_lc <= CH_F);
  assign is_delim = !is_x && !is_dec && !is_alpha;
  assign hex      = hex_default_i || hov_q;
  assign take     = is_dec || (is_alpha && hex);
  assign dval     = is_dec ? c_lc[3:0] : 4'(c_lc[3:0] + 4'd9);

  assign acc_hex = {acc_q[AccW-5:0], dval};
  assign acc_dec = (acc_q << 3) + (acc_q << 1) + {{(AccW-4){1'b0}}, dval};
  assign acc_new = hex ? acc_hex : acc_dec;

  assign emit = (is_delim && seen_q) || (end_of_stream_i && (seen_q || take));

  assign q_push_o.push  = accept && emit;
  assign q_push_o.value = take ? acc_new : acc_q;

  always_comb begin
    acc_d  = acc_q;
    seen_d = seen_q;
    hov_d  = hov_q;
    if (accept) begin
      priority if (end_of_stream_i || (is_delim && seen_q)) begin
        acc_d  = '0;
        seen_d = 1'b0;
        hov_d  = 1'b0;
      end else if (is_x) begin
        hov_d = 1'b1;
      end else if (take) begin
        acc_d  = acc_new;
        seen_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      seen_q <= 1'b0;
      hov_q  <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      seen_q <= seen_d;
      hov_q  <= hov_d;
    end
  end

endmodule

>>> hdl/nts_queue.sv
`include "number_text_to_bit_string_unit_assert.svh"

module nts_queue
  import nts_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_push_t q_push_i,
  input  logic    pop_i,
  output q_head_t q_head_o,
  output logic    full_o
);

  localparam int unsigned Depth = 2;

  logic [AccW-1:0] mem_q [Depth];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            do_push, do_pop;

  assign full_o         = (cnt_q == 2'(Depth));
  assign q_head_o.valid = (cnt_q != 2'd0);
  assign q_head_o.value = mem_q[rd_ptr_q];

  assign do_push = q_push_i.push;
  assign do_pop  = pop_i && q_head_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= q_push_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `NTS_ASSERT(queue_no_overflow, (do_push && !do_pop) |-> (cnt_q != 2'(Depth)))
  `NTS_ASSERT_RST(queue_empty_after_reset, !rst_ni |=> (cnt_q == 2'd0))

endmodule

>>> hdl/nts_back.sv
`include "number_text_to_bit_string_unit_assert.svh"

module nts_back
  import nts_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] width_select_i,
  input  q_head_t    q_head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [5:0] bit_char_o,
  output logic       last_bit_o
);

  logic [AccW-1:0] sh_q, sh_d, aligned;
  logic [CntW-1:0] cnt_q, cnt_d, nbits;
  logic            busy_q, busy_d;
  logic            load;

  assign out_valid_o = busy_q;
  assign bit_char_o  = {BIT_CHAR_HI, sh_q[AccW-1]};
  assign last_bit_o  = (cnt_q == CntW'(1));

  assign load  = q_head_i.valid && (!busy_q || (out_ready_i && last_bit_o));
  assign pop_o = load;

  always_comb begin
    unique case (width_select_i)
      WSEL_8: begin
        aligned = {q_head_i.value[7:0], 56'd0};
        nbits   = CntW'(8);
      end
      WSEL_16: begin
        aligned = {q_head_i.value[15:0], 48'd0};
        nbits   = CntW'(16);
      end
      WSEL_32: begin
        aligned = {q_head_i.value[31:0], 32'd0};
        nbits   = CntW'(32);
      end
      WSEL_64: begin
        aligned = q_head_i.value;
        nbits   = CntW'(64);
      end
      default: begin
        aligned = q_head_i.value;
        nbits   = CntW'(64);
      end
    endcase
  end

  always_comb begin
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (busy_q && out_ready_i) begin
      sh_d  = sh_q << 1;
      cnt_d = cnt_q - CntW'(1);
      if (last_bit_o) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      sh_d   = aligned;
      cnt_d  = nbits;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  `NTS_ASSERT(back_busy_has_bits, busy_q |-> (cnt_q != '0))
  `NTS_ASSERT(back_idle_no_bits, !busy_q |-> (cnt_q == '0))
  `NTS_ASSERT(back_holds_midword, (busy_q && !last_bit_o) |=> busy_q)

endmodule

>>> hdl/number_text_to_bit_string_unit.sv
// Number text to bit string converter.
// The input channel (in_valid_i/in_ready_o) takes one text character per beat,
// with end_of_stream_i marking the last character of a stream. Digits 0-9 and
// a-f (hex mode only) build a 64-bit number; x switches the number to hex, and
// any other byte ends a pending number.
// The output channel (out_valid_o/out_ready_i) gives one beat per bit, as ASCII
// '0' or '1', most significant bit first, with last_bit_o on the final bit.
// Each number gives 8, 16, 32 or 64 beats, as width_select chooses.
// The configuration channel writes register 0 (hex_default) and register 1
// (width_select); writes are taken every cycle and belong to idle periods.
// Throughput is one character per cycle while in_ready_o is high. A number
// goes from the queue into the back end's shift register once it is free, and
// is sent one bit per cycle while out_ready_i is high. Two finished numbers can
// wait in the queue between the parser and the serializer; whenever the queue
// is full, in_ready_o drops until the serializer frees an entry.
// Reset clears the configuration, the pending number and the queue.
module number_text_to_bit_string_unit
  import nts_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [1:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       end_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [5:0] bit_char_o,
  output logic       last_bit_o
);

  logic       hex_default_q;
  logic [1:0] width_select_q;
  q_push_t    q_push;
  q_head_t    q_head;
  logic       q_full, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hex_default_q  <= 1'b0;
      width_select_q <= WSEL_8;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_HEX_DEFAULT) begin
        hex_default_q <= cfg_data_i[0];
      end
      if (cfg_index_i == CFG_WIDTH_SELECT) begin
        width_select_q <= cfg_data_i;
      end
    end
  end

  nts_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .hex_default_i   (hex_default_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_in_i       (char_in_i),
    .end_of_stream_i (end_of_stream_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push)
  );

  nts_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_push_i (q_push),
    .pop_i    (q_pop),
    .q_head_o (q_head),
    .full_o   (q_full)
  );

  nts_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .width_select_i (width_select_q),
    .q_head_i       (q_head),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .bit_char_o     (bit_char_o),
    .last_bit_o     (last_bit_o)
  );

endmodule

>>> verif/number_text_to_bit_string_unit_tb.sv
module number_text_to_bit_string_unit_tb;
  import nts_pkg::*;

  localparam logic [5:0] BitCharZero = 6'd48;
  localparam int IdlePct = 29;
  localparam int PhaseChars = 52;

  typedef struct {
    logic [7:0] ch;
    logic       eos;
  } text_char_t;

  typedef struct packed {
    logic [5:0] bit_char;
    logic       last_bit;
  } bit_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [1:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] char_in_i = '0;
  logic       end_of_stream_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [5:0] bit_char_o;
  logic       last_bit_o;

  text_char_t char_q[$];
  bit_beat_t  beat_q[$];

  logic        hex_default_m;
  logic [1:0]  width_select_m;
  logic [63:0] number_acc;
  logic        digit_seen;
  logic        hex_override;

  bit calm_in;
  bit calm_out;
  int hold_cycles;
  int n_gen;
  int n_chars;
  int n_beats;
  int n_numbers;
  int n_settings;
  int n_err;

  bit         hex_plan [6];
  logic [1:0] wsel_plan [6];

  number_text_to_bit_string_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_in_i      (char_in_i),
    .end_of_stream_i(end_of_stream_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .bit_char_o     (bit_char_o),
    .last_bit_o     (last_bit_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic void emit_bits();
    int nbits;
    bit_beat_t b;
    nbits = 8 << width_select_m;
    for (int k = 0; k < nbits; k++) begin
      b.bit_char = BitCharZero + {5'd0, number_acc[nbits-1-k]};
      b.last_bit = (k == nbits - 1);
      beat_q.push_back(b);
    end
    number_acc = '0;
    digit_seen = 1'b0;
    hex_override = 1'b0;
  endfunction

  function automatic void convert_char(input logic [7:0] ch, input logic eos);
    logic [7:0]  c;
    logic [63:0] dig;
    logic        is_dec;
    logic        is_alpha;
    c = ch;
    if (c >= CH_UA && c <= CH_UZ) c = c + CASE_OFS;
    is_dec = (c >= CH_0 && c <= CH_9);
    is_alpha = (c >= CH_A && c <= CH_F);
    if (c == CH_X) begin
      hex_override = 1'b1;
    end else if (is_dec || is_alpha) begin
      if (hex_default_m || hex_override) begin
        dig = is_dec ? 64'(c - CH_0) : 64'(c - CH_A) + 64'd10;
        number_acc = (number_acc << 4) + dig;
        digit_seen = 1'b1;
      end else if (is_dec) begin
        dig = 64'(c - CH_0);
        number_acc = number_acc * 64'd10 + dig;
        digit_seen = 1'b1;
      end
    end else if (digit_seen) begin
      emit_bits();
    end
    if (eos) begin
      if (digit_seen) emit_bits();
      number_acc = '0;
      digit_seen = 1'b0;
      hex_override = 1'b0;
    end
  endfunction

  function automatic void push_char(input logic [7:0] ch, input logic eos);
    text_char_t t;
    t.ch = ch;
    t.eos = eos;
    char_q.push_back(t);
    n_gen++;
  endfunction

  function automatic void push_text(input string s, input logic eos_last);
    for (int i = 0; i < s.len(); i++) push_char(s[i], eos_last && (i == s.len() - 1));
  endfunction

  function automatic logic [7:0] rand_delim();
    logic [7:0] ch;
    logic [7:0] lc;
    do begin
      ch = 8'($urandom_range(0, 255));
      lc = (ch >= CH_UA && ch <= CH_UZ) ? ch + CASE_OFS : ch;
    end while ((lc >= CH_0 && lc <= CH_9) || (lc >= CH_A && lc <= CH_F) || lc == CH_X);
    return ch;
  endfunction

  function automatic logic [7:0] rand_digit(input bit hex);
    logic [7:0] ch;
    if (!hex || $urandom_range(0, 15) < 10) return CH_0 + 8'($urandom_range(0, 9));
    ch = CH_A + 8'($urandom_range(0, 5));
    if ($urandom_range(0, 1)) ch = ch - CASE_OFS;
    return ch;
  endfunction

  function automatic void push_number(input bit hex_mode);
    bit hex;
    int len;
    hex = hex_mode;
    if ($urandom_range(0, 3) == 0) begin
      push_char(CH_0, 1'b0);
      push_char($urandom_range(0, 1) ? CH_X : CH_X - CASE_OFS, 1'b0);
      hex = 1'b1;
    end
    len = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 25) : $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      if (!hex && $urandom_range(0, 7) == 0) push_char(CH_A + 8'($urandom_range(0, 5)), 1'b0);
      push_char(rand_digit(hex), (i == len - 1) && ($urandom_range(0, 9) == 0));
    end
    if (!char_q[$].eos) push_char(rand_delim(), $urandom_range(0, 9) == 0);
  endfunction

  function automatic void push_random(input int count, input bit hex_mode);
    int start;
    start = n_gen;
    while (n_gen - start < count) begin
      if ($urandom_range(0, 3) != 0) push_number(hex_mode);
      else push_char(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
    end
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_HEX_DEFAULT) hex_default_m = val[0];
    else if (idx == CFG_WIDTH_SELECT) width_select_m = val;
  endtask

  task automatic wait_drained();
    while (char_q.size() != 0 || in_valid_i || beat_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : sender_p
    text_char_t t;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (char_q.size() != 0 && (calm_in || $urandom_range(0, 99) >= IdlePct)) begin
        t = char_q.pop_front();
        in_valid_i <= 1'b1;
        char_in_i <= t.ch;
        end_of_stream_i <= t.eos;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm_out || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin : monitor_p
    bit_beat_t e;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        convert_char(char_in_i, end_of_stream_i);
        n_chars++;
      end
      if (out_valid_o && out_ready_i) begin
        n_beats++;
        if (last_bit_o) n_numbers++;
        if (beat_q.size() == 0) begin
          $error("unexpected bit beat: bit_char %0d, last_bit %0d", bit_char_o, last_bit_o);
          n_err++;
        end else begin
          e = beat_q.pop_front();
          if (bit_char_o !== e.bit_char) begin
            $error("bit_char: expected %0d, actual %0d", e.bit_char, bit_char_o);
            n_err++;
          end
          if (last_bit_o !== e.last_bit) begin
            $error("last_bit: expected %0d, actual %0d", e.last_bit, last_bit_o);
            n_err++;
          end
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    hex_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    wsel_plan = '{WSEL_64, WSEL_8, WSEL_64, WSEL_16, WSEL_32, WSEL_8};
    hex_default_m = 1'b0;
    width_select_m = WSEL_8;
    number_acc = '0;
    digit_seen = 1'b0;
    hex_override = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(CFG_HEX_DEFAULT, 2'd0);
    write_reg(CFG_WIDTH_SELECT, WSEL_8);
    n_settings = 1;

    push_text("255 ", 1'b0);
    push_text("0XfF", 1'b0);
    push_char(8'h80, 1'b0);
    push_text("a9b", 1'b0);
    push_char(8'hff, 1'b0);
    push_text("x 1A", 1'b1);
    push_text("7,", 1'b1);
    push_text("\n", 1'b1);
    push_char(CH_0, 1'b0);
    push_char(8'h00, 1'b0);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_HEX_DEFAULT, {1'b0, hex_plan[p]});
      write_reg(CFG_WIDTH_SELECT, wsel_plan[p]);
      n_settings++;
      @(negedge clk_i);
      calm_in = (p == 1 || p == 2);
      calm_out = (p == 1);
      if (p == 2) hold_cycles = 300;
      if (p == 3) begin
        push_random(PhaseChars / 2, hex_plan[p]);
        wait_drained();
        push_random(PhaseChars / 2, hex_plan[p]);
      end else begin
        push_random(PhaseChars, hex_plan[p]);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    $display("Sent %0d text characters under %0d register settings.", n_chars, n_settings);
    $display("Checked %0d bit beats forming %0d numbers.", n_beats, n_numbers);
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> number_text_to_bit_string_unit.f
+incdir+hdl
hdl/nts_pkg.sv
hdl/nts_front.sv
hdl/nts_queue.sv
hdl/nts_back.sv
hdl/number_text_to_bit_string_unit.sv
verif/number_text_to_bit_string_unit_tb.sv
